FILE: rtl/gise_pkg.sv
`timescale 1ns / 1ps

package gise_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES = 8192;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int EPTR_W = 14;
  localparam int TALLY_W = 11;
  localparam int FR_W = VIDX_W + 1;

  typedef enum logic [1:0] {
    OP_LOAD_VERTEX = 2'd0,
    OP_LOAD_EDGE   = 2'd1,
    OP_RUN         = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  localparam logic [1:0] ST_UNDECIDED = 2'd0;
  localparam logic [1:0] ST_SELECTED = 2'd1;
  localparam logic [1:0] ST_REMOVED = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_CNT_U,
    S_CNT_SPAN,
    S_CNT_E,
    S_CNT_ADJ,
    S_CNT_RANK,
    S_CNT_WR,
    S_ROUND,
    S_P1_RD,
    S_P1_U,
    S_P1_ST,
    S_P2_RD,
    S_P2_U,
    S_P2_SPAN,
    S_P2_E,
    S_P2_ADJ,
    S_P2_VST,
    S_P2_VSPAN,
    S_P2_F,
    S_P2_FADJ,
    S_P2_W,
    S_SWAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [EPTR_W-1:0] start;
    logic [EPTR_W-1:0] stop;
    logic [VIDX_W-1:0] rank;
  } vrec_t;

  typedef struct packed {
    logic load_vertex;
    logic load_edge;
    logic query;
    logic run;
    logic [VIDX_W-1:0] vertex;
    logic [VIDX_W-1:0] prio;
    logic [EPTR_W-1:0] first_edge;
    logic [EPTR_W-1:0] end_edge;
    logic [EIDX_W-1:0] slot;
    logic [VIDX_W-1:0] neighbor;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [1:0] vstate;
    logic [TALLY_W-1:0] set_size;
    logic [TALLY_W-1:0] round_total;
  } core_stat_t;

  function automatic logic [EPTR_W-1:0] clip_end(input logic [EPTR_W-1:0] e);
    return (e > EPTR_W'(MAX_EDGES)) ? EPTR_W'(MAX_EDGES) : e;
  endfunction

endpackage

FILE: rtl/gise_core.sv
`timescale 1ns / 1ps

module gise_core (
  input  logic clk,
  input  logic rst,
  input  gise_pkg::cmd_t cmd,
  input  logic [gise_pkg::TALLY_W-1:0] vertex_count,
  output gise_pkg::core_stat_t stat
);

  localparam int VW = gise_pkg::VIDX_W;
  localparam int EW = gise_pkg::EIDX_W;
  localparam int PW = gise_pkg::EPTR_W;
  localparam int TW = gise_pkg::TALLY_W;
  localparam int FW = gise_pkg::FR_W;

  gise_pkg::state_t state, state_next;

  gise_pkg::vrec_t vmem [gise_pkg::MAX_VERTICES];
  logic [VW-1:0] adj [gise_pkg::MAX_EDGES];
  logic [1:0] stmem [gise_pkg::MAX_VERTICES];
  logic [PW-1:0] blk [gise_pkg::MAX_VERTICES];
  logic [FW-1:0] fr [2*gise_pkg::MAX_VERTICES];

  gise_pkg::vrec_t vm_q;
  logic [VW-1:0] adj_q;
  logic [1:0] st_q;
  logic [PW-1:0] blk_q;
  logic [FW-1:0] fr_q;

  logic vm_re, adj_re, st_re, st_we, blk_re, blk_we, fr_re, fr_we;
  logic [VW-1:0] vm_ra, st_ra, st_wa, blk_ra, blk_wa;
  logic [EW-1:0] adj_ra;
  logic [1:0] st_wd;
  logic [PW-1:0] blk_wd;
  logic [FW-1:0] fr_ra, fr_wa, fr_wd;

  logic running, cur;
  logic [TW-1:0] idx, len, nlen, rounds, sel, set_size, round_total;
  logic [PW-1:0] e_ptr, e_end, f_ptr, f_end, cnt;
  logic [VW-1:0] u_rank, v_rank, v, w;

  logic adj_in, fr_in, rel;

  assign adj_in = {1'b0, adj_q} < vertex_count;
  assign fr_in = fr_q < vertex_count;
  assign rel = (st_q == gise_pkg::ST_UNDECIDED) && (vm_q.rank > v_rank) && (blk_q != '0);

  always_ff @(posedge clk) begin
    if (cmd.load_vertex && state == gise_pkg::S_IDLE) begin
      vmem[cmd.vertex] <= '{start: cmd.first_edge, stop: cmd.end_edge, rank: cmd.prio};
    end
    if (vm_re) begin
      vm_q <= vmem[vm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge && state == gise_pkg::S_IDLE) begin
      adj[cmd.slot] <= cmd.neighbor;
    end
    if (adj_re) begin
      adj_q <= adj[adj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stmem[st_wa] <= st_wd;
    end
    if (st_re) begin
      st_q <= stmem[st_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk[blk_wa] <= blk_wd;
    end
    if (blk_re) begin
      blk_q <= blk[blk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      fr[fr_wa] <= fr_wd;
    end
    if (fr_re) begin
      fr_q <= fr[fr_ra];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gise_pkg::S_IDLE: if (cmd.run) state_next = gise_pkg::S_CLEAR;
      gise_pkg::S_CLEAR: begin
        if (idx[VW-1:0] == VW'(gise_pkg::MAX_VERTICES - 1)) begin
          state_next = running ? gise_pkg::S_CNT_U : gise_pkg::S_IDLE;
        end
      end
      gise_pkg::S_CNT_U:
        state_next = (idx == vertex_count) ? gise_pkg::S_ROUND : gise_pkg::S_CNT_SPAN;
      gise_pkg::S_CNT_SPAN: state_next = gise_pkg::S_CNT_E;
      gise_pkg::S_CNT_E:
        state_next = (e_ptr >= e_end) ? gise_pkg::S_CNT_WR : gise_pkg::S_CNT_ADJ;
      gise_pkg::S_CNT_ADJ: state_next = adj_in ? gise_pkg::S_CNT_RANK : gise_pkg::S_CNT_E;
      gise_pkg::S_CNT_RANK: state_next = gise_pkg::S_CNT_E;
      gise_pkg::S_CNT_WR: state_next = gise_pkg::S_CNT_U;
      gise_pkg::S_ROUND: state_next = (len == '0) ? gise_pkg::S_DONE : gise_pkg::S_P1_RD;
      gise_pkg::S_P1_RD: state_next = (idx == len) ? gise_pkg::S_P2_RD : gise_pkg::S_P1_U;
      gise_pkg::S_P1_U: state_next = gise_pkg::S_P1_ST;
      gise_pkg::S_P1_ST: state_next = gise_pkg::S_P1_RD;
      gise_pkg::S_P2_RD: state_next = (idx == len) ? gise_pkg::S_SWAP : gise_pkg::S_P2_U;
      gise_pkg::S_P2_U: state_next = fr_in ? gise_pkg::S_P2_SPAN : gise_pkg::S_P2_RD;
      gise_pkg::S_P2_SPAN: state_next = gise_pkg::S_P2_E;
      gise_pkg::S_P2_E: state_next = (e_ptr >= e_end) ? gise_pkg::S_P2_RD : gise_pkg::S_P2_ADJ;
      gise_pkg::S_P2_ADJ: state_next = adj_in ? gise_pkg::S_P2_VST : gise_pkg::S_P2_E;
      gise_pkg::S_P2_VST:
        state_next = (st_q == gise_pkg::ST_UNDECIDED) ? gise_pkg::S_P2_VSPAN : gise_pkg::S_P2_E;
      gise_pkg::S_P2_VSPAN: state_next = gise_pkg::S_P2_F;
      gise_pkg::S_P2_F: state_next = (f_ptr >= f_end) ? gise_pkg::S_P2_E : gise_pkg::S_P2_FADJ;
      gise_pkg::S_P2_FADJ: state_next = adj_in ? gise_pkg::S_P2_W : gise_pkg::S_P2_F;
      gise_pkg::S_P2_W: state_next = gise_pkg::S_P2_F;
      gise_pkg::S_SWAP: state_next = gise_pkg::S_ROUND;
      gise_pkg::S_DONE: state_next = gise_pkg::S_IDLE;
      default: state_next = gise_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    vm_re = 1'b0;
    vm_ra = '0;
    adj_re = 1'b0;
    adj_ra = '0;
    st_re = 1'b0;
    st_ra = '0;
    st_we = 1'b0;
    st_wa = '0;
    st_wd = gise_pkg::ST_UNDECIDED;
    blk_re = 1'b0;
    blk_ra = '0;
    blk_we = 1'b0;
    blk_wa = '0;
    blk_wd = '0;
    fr_re = 1'b0;
    fr_ra = '0;
    fr_we = 1'b0;
    fr_wa = '0;
    fr_wd = '0;
    unique case (state)
      gise_pkg::S_IDLE: begin
        st_re = cmd.query;
        st_ra = cmd.vertex;
      end
      gise_pkg::S_CLEAR: begin
        st_we = 1'b1;
        st_wa = idx[VW-1:0];
      end
      gise_pkg::S_CNT_U: begin
        vm_re = idx != vertex_count;
        vm_ra = idx[VW-1:0];
      end
      gise_pkg::S_CNT_E, gise_pkg::S_P2_E: begin
        adj_re = e_ptr < e_end;
        adj_ra = e_ptr[EW-1:0];
      end
      gise_pkg::S_CNT_ADJ: begin
        vm_re = adj_in;
        vm_ra = adj_q;
      end
      gise_pkg::S_CNT_WR: begin
        blk_we = 1'b1;
        blk_wa = idx[VW-1:0];
        blk_wd = cnt;
        fr_we = cnt == '0;
        fr_wa = {cur, len[VW-1:0]};
        fr_wd = {1'b0, idx[VW-1:0]};
      end
      gise_pkg::S_P1_RD, gise_pkg::S_P2_RD: begin
        fr_re = idx != len;
        fr_ra = {cur, idx[VW-1:0]};
      end
      gise_pkg::S_P1_U: begin
        st_re = 1'b1;
        st_ra = fr_q[VW-1:0];
      end
      gise_pkg::S_P1_ST: begin
        if (st_q == gise_pkg::ST_UNDECIDED) begin
          st_we = 1'b1;
          st_wa = v;
          st_wd = gise_pkg::ST_SELECTED;
        end else begin
          fr_we = 1'b1;
          fr_wa = {cur, idx[VW-1:0]};
          fr_wd = FW'(gise_pkg::MAX_VERTICES);
        end
      end
      gise_pkg::S_P2_U: begin
        vm_re = fr_in;
        vm_ra = fr_q[VW-1:0];
      end
      gise_pkg::S_P2_ADJ: begin
        st_re = adj_in;
        st_ra = adj_q;
      end
      gise_pkg::S_P2_VST: begin
        if (st_q == gise_pkg::ST_UNDECIDED) begin
          st_we = 1'b1;
          st_wa = v;
          st_wd = gise_pkg::ST_REMOVED;
          vm_re = 1'b1;
          vm_ra = v;
        end
      end
      gise_pkg::S_P2_F: begin
        adj_re = f_ptr < f_end;
        adj_ra = f_ptr[EW-1:0];
      end
      gise_pkg::S_P2_FADJ: begin
        st_re = adj_in;
        st_ra = adj_q;
        blk_re = adj_in;
        blk_ra = adj_q;
        vm_re = adj_in;
        vm_ra = adj_q;
      end
      gise_pkg::S_P2_W: begin
        blk_we = rel;
        blk_wa = w;
        blk_wd = blk_q - PW'(1);
        fr_we = rel && (blk_q == PW'(1)) && !nlen[TW-1];
        fr_wa = {~cur, nlen[VW-1:0]};
        fr_wd = {1'b0, w};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gise_pkg::S_CLEAR;
      running <= 1'b0;
      idx <= '0;
      set_size <= '0;
      round_total <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        gise_pkg::S_IDLE: begin
          if (cmd.run) begin
            running <= 1'b1;
            idx <= '0;
            len <= '0;
            rounds <= '0;
            sel <= '0;
            cur <= 1'b0;
          end
        end
        gise_pkg::S_CLEAR: begin
          idx <= (idx[VW-1:0] == VW'(gise_pkg::MAX_VERTICES - 1)) ? '0 : idx + TW'(1);
        end
        gise_pkg::S_CNT_U: cnt <= '0;
        gise_pkg::S_CNT_SPAN: begin
          e_ptr <= vm_q.start;
          e_end <= gise_pkg::clip_end(vm_q.stop);
          u_rank <= vm_q.rank;
        end
        gise_pkg::S_CNT_ADJ: if (!adj_in) e_ptr <= e_ptr + PW'(1);
        gise_pkg::S_CNT_RANK: begin
          if (vm_q.rank < u_rank) cnt <= cnt + PW'(1);
          e_ptr <= e_ptr + PW'(1);
        end
        gise_pkg::S_CNT_WR: begin
          if (cnt == '0) len <= len + TW'(1);
          idx <= idx + TW'(1);
        end
        gise_pkg::S_ROUND: begin
          if (len != '0) begin
            rounds <= rounds + TW'(1);
            nlen <= '0;
            idx <= '0;
          end
        end
        gise_pkg::S_P1_RD: if (idx == len) idx <= '0;
        gise_pkg::S_P1_U: v <= fr_q[VW-1:0];
        gise_pkg::S_P1_ST: begin
          if (st_q == gise_pkg::ST_UNDECIDED) sel <= sel + TW'(1);
          idx <= idx + TW'(1);
        end
        gise_pkg::S_P2_U: if (!fr_in) idx <= idx + TW'(1);
        gise_pkg::S_P2_SPAN: begin
          e_ptr <= vm_q.start;
          e_end <= gise_pkg::clip_end(vm_q.stop);
        end
        gise_pkg::S_P2_E: if (e_ptr >= e_end) idx <= idx + TW'(1);
        gise_pkg::S_P2_ADJ: begin
          v <= adj_q;
          if (!adj_in) e_ptr <= e_ptr + PW'(1);
        end
        gise_pkg::S_P2_VST: if (st_q != gise_pkg::ST_UNDECIDED) e_ptr <= e_ptr + PW'(1);
        gise_pkg::S_P2_VSPAN: begin
          f_ptr <= vm_q.start;
          f_end <= gise_pkg::clip_end(vm_q.stop);
          v_rank <= vm_q.rank;
        end
        gise_pkg::S_P2_F: if (f_ptr >= f_end) e_ptr <= e_ptr + PW'(1);
        gise_pkg::S_P2_FADJ: begin
          w <= adj_q;
          if (!adj_in) f_ptr <= f_ptr + PW'(1);
        end
        gise_pkg::S_P2_W: begin
          if (rel && (blk_q == PW'(1)) && !nlen[TW-1]) nlen <= nlen + TW'(1);
          f_ptr <= f_ptr + PW'(1);
        end
        gise_pkg::S_SWAP: begin
          cur <= ~cur;
          len <= nlen;
        end
        gise_pkg::S_DONE: begin
          set_size <= sel;
          round_total <= rounds;
          running <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.busy = state != gise_pkg::S_IDLE;
  assign stat.done = state == gise_pkg::S_DONE;
  assign stat.vstate = st_q;
  assign stat.set_size = set_size;
  assign stat.round_total = round_total;

endmodule

FILE: rtl/greedy_independent_set_engine.sv
`timescale 1ns / 1ps

// Load-vertex, load-edge and query items are taken one per cycle while in_stall is
// low; each result waits in a pending register and moves to the output registers
// when the output is not stalled. A run item holds the input stalled while a single
// sequencer walks the vertex, edge, status, blocker and frontier memories one access
// step at a time: a status clearing pass over all 1024 vertices, then a counting
// pass and the frontier rounds, each visiting edges. After reset the same status
// clearing pass runs before the first item is taken.
module greedy_independent_set_engine (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wen,
  input  logic [10:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] operation,
  input  logic [9:0] vertex,
  input  logic [9:0] priority_req,
  input  logic [13:0] first_edge,
  input  logic [13:0] end_edge,
  input  logic [12:0] edge_slot,
  input  logic [9:0] neighbor,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] vertex_state,
  output logic [10:0] set_size,
  output logic [10:0] round_total,
  output logic accepted
);

  localparam int TW = gise_pkg::TALLY_W;

  logic [TW-1:0] vertex_count;
  gise_pkg::cmd_t cmd;
  gise_pkg::core_stat_t stat;
  gise_pkg::op_t op;

  logic take, ok, move;
  logic pend, pend_ok, pend_query;

  assign op = gise_pkg::op_t'(operation);
  assign take = in_valid && !in_stall;
  assign move = pend && (!out_valid || !out_stall);
  assign in_stall = stat.busy || (pend && out_valid && out_stall);

  always_comb begin
    unique case (op)
      gise_pkg::OP_LOAD_VERTEX:
        ok = ({1'b0, vertex} < TW'(gise_pkg::MAX_VERTICES)) && (first_edge <= end_edge) &&
             (end_edge <= 14'(gise_pkg::MAX_EDGES));
      gise_pkg::OP_LOAD_EDGE:
        ok = ({1'b0, edge_slot} < 14'(gise_pkg::MAX_EDGES)) &&
             ({1'b0, neighbor} < TW'(gise_pkg::MAX_VERTICES));
      gise_pkg::OP_RUN: ok = vertex_count <= TW'(gise_pkg::MAX_VERTICES);
      gise_pkg::OP_QUERY: ok = {1'b0, vertex} < TW'(gise_pkg::MAX_VERTICES);
      default: ok = 1'b0;
    endcase
  end

  assign cmd.load_vertex = take && ok && (op == gise_pkg::OP_LOAD_VERTEX);
  assign cmd.load_edge = take && ok && (op == gise_pkg::OP_LOAD_EDGE);
  assign cmd.query = take && ok && (op == gise_pkg::OP_QUERY);
  assign cmd.run = take && ok && (op == gise_pkg::OP_RUN);
  assign cmd.vertex = vertex;
  assign cmd.prio = priority_req;
  assign cmd.first_edge = first_edge;
  assign cmd.end_edge = end_edge;
  assign cmd.slot = edge_slot;
  assign cmd.neighbor = neighbor;

  gise_core u_core (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .vertex_count(vertex_count),
    .stat(stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wen) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (stat.done) begin
        pend <= 1'b1;
        pend_ok <= 1'b1;
        pend_query <= 1'b0;
      end else if (take && !cmd.run) begin
        pend <= 1'b1;
        pend_ok <= ok;
        pend_query <= op == gise_pkg::OP_QUERY;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
        vertex_state <= (pend_query && pend_ok) ? stat.vstate : gise_pkg::ST_UNDECIDED;
        set_size <= stat.set_size;
        round_total <= stat.round_total;
        accepted <= pend_ok;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
